// ----- sv/aenc_pkg.sv -----
// aenc_pkg: constants shared by the 31-bit arithmetic encoder and its divider.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aenc_pkg;
   localparam int RANGE_W = 31;
   localparam int CNT_W   = 16;
   localparam int DVD_W   = 32;

   localparam logic [RANGE_W-1:0] Q1   = 31'h2000_0000;
   localparam logic [RANGE_W-1:0] HALF = 31'h4000_0000;
   localparam logic [RANGE_W-1:0] Q3   = 31'h6000_0000;
   localparam logic [RANGE_W-1:0] TOP  = 31'h7FFF_FFFF;

   localparam int MAX_OUT     = 9;
   localparam int BUF_AW      = $clog2(MAX_OUT);
   localparam int BUF_CW      = $clog2(MAX_OUT + 1);

   localparam int PENDING_MAX_DEF = 32;
   localparam int COUNT_BITS_DEF  = 16;

   localparam logic ACT_ENCODE = 1'b0;
   localparam logic ACT_FINISH = 1'b1;
endpackage
`default_nettype wire

// ----- sv/aenc_div.sv -----
// aenc_div: restoring divider, one quotient bit per cycle.
// Depends on aenc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aenc_div
   import aenc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);
   localparam int IW = $clog2(DVD_W);

   logic             busy_ff;
   logic             done_ff;
   logic [IW-1:0]    iter_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [CNT_W:0]   rem_sh;
   logic [CNT_W-1:0] rem_in;
   logic             qbit;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DVD_W-1]};
      if (rem_sh >= {1'b0, divisor}) begin
         qbit   = 1'b1;
         rem_in = CNT_W'(rem_sh - {1'b0, divisor});
      end else begin
         qbit   = 1'b0;
         rem_in = rem_sh[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            iter_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[DVD_W-2:0], qbit};
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == IW'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ----- sv/arithmetic_encoder_31bit_top.sv -----
// arithmetic_encoder_31bit_top: 31-bit integer arithmetic encoder with byte output.
// Depends on aenc_pkg and aenc_div.
`timescale 1ns / 1ps
`default_nettype none
// Integer arithmetic encoder with a 31-bit interval. Each req transaction is
// either an encode (cumulative counts sym_low/sym_high of a symbol out of total)
// or a finish, which writes the termination bits, zero-pads the last byte and
// returns the coder to its reset state. An encode with total zero, sym_high not
// above sym_low or sym_high above total is dropped without any rsp transaction.
// Coded bytes come out MSB first; last marks the final byte of the transaction
// and overflow is set on all its bytes when the underflow counter saturated at
// PENDING_MAX. The block works on one transaction at a time and holds
// req_stall high until every byte it produced has been taken. An encode runs
// the bit-serial divider that forms range/total, then the multiply/add steps,
// then shifts out each emitted bit, takes each underflow scaling step and hands
// out each byte. A finish shifts out each termination and pad bit and then
// hands out each byte. Up to 9 bytes are buffered per transaction; any further
// bytes are discarded.
module arithmetic_encoder_31bit_top
   import aenc_pkg::*;
#(
   parameter int PENDING_MAX = PENDING_MAX_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [15:0] req_sym_low,
   input  wire logic [15:0] req_sym_high,
   input  wire logic [15:0] req_total,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_overflow
);
   localparam int PW = $clog2(PENDING_MAX + 1);
   // counts pending bits plus the extra termination bit
   localparam int EW = PW + 1;
   localparam logic [CNT_W-1:0] CMASK =
      (COUNT_BITS >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((32'd1 << COUNT_BITS) - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_MULH, S_MULL, S_ADDL, S_SHIFT,
      S_PEND, S_UFLOW, S_FIN, S_PAD, S_OUT
   } state_type;

   state_type          state_ff;
   logic [RANGE_W-1:0] low_ff, high_ff, prod_ff;
   logic [PW-1:0]      pend_ff;
   logic [EW-1:0]      emit_ff;
   logic [6:0]         shift_ff;
   logic [2:0]         nbits_ff;
   logic               cur_bit_ff, ovf_ff;
   logic [CNT_W-1:0]   slo_ff, shi_ff, tot_ff;
   logic [7:0]         buf_ff [MAX_OUT];
   logic [BUF_CW-1:0]  wr_cnt_ff;
   logic [BUF_CW-1:0]  rd_ff;
   // finish in progress: set on accept of a finish, cleared on the next accept
   logic               fin_ff;

   // incoming transaction
   logic [CNT_W-1:0] slo_m, shi_m, tot_m;
   logic             req_ok, req_take;

   assign slo_m    = req_sym_low  & CMASK;
   assign shi_m    = req_sym_high & CMASK;
   assign tot_m    = req_total    & CMASK;
   assign req_ok   = !(tot_m == '0 || shi_m <= slo_m || shi_m > tot_m);
   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // shared divider: range / total, divisor held in tot_ff for the whole run
   logic             div_start, div_done;
   logic [DVD_W-1:0] div_q, range_w;

   assign range_w   = DVD_W'({1'b0, high_ff} - {1'b0, low_ff}) + DVD_W'(1);
   assign div_start = req_take && req_action == ACT_ENCODE && req_ok;

   aenc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (range_w),
      .divisor  (tot_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // shared multiplier, one product per cycle
   logic [CNT_W-1:0]       mul_b;
   logic [DVD_W+CNT_W-1:0] mul_p;
   assign mul_b = (state_ff == S_MULH) ? shi_ff : slo_ff;
   assign mul_p = div_q * mul_b;

   // bit packer
   logic       pb_en, pb_bit, pb_done;
   logic [6:0] shift_in;
   logic [2:0] nbits_in;
   logic       renorm, uflow;

   assign renorm = (high_ff < HALF) || (low_ff >= HALF);
   assign uflow  = (low_ff >= Q1) && (high_ff < Q3);

   always_comb begin
      pb_en  = 1'b0;
      pb_bit = 1'b0;
      unique case (state_ff)
         S_SHIFT: begin
            pb_en  = renorm;
            pb_bit = low_ff[RANGE_W-1];
         end
         S_PEND: begin
            pb_en  = 1'b1;
            pb_bit = !cur_bit_ff;
         end
         S_FIN: begin
            pb_en  = 1'b1;
            pb_bit = (low_ff >= Q1);
         end
         S_PAD: begin
            pb_en  = (nbits_ff != '0);
            pb_bit = 1'b0;
         end
         default: begin
            pb_en  = 1'b0;
            pb_bit = 1'b0;
         end
      endcase
      pb_done  = pb_en && (nbits_ff == 3'd7);
      shift_in = pb_done ? 7'd0 : {shift_ff[5:0], pb_bit};
      nbits_in = nbits_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         low_ff     <= '0;
         high_ff    <= TOP;
         pend_ff    <= '0;
         emit_ff    <= '0;
         shift_ff   <= '0;
         nbits_ff   <= '0;
         cur_bit_ff <= 1'b0;
         ovf_ff     <= 1'b0;
         wr_cnt_ff  <= '0;
         rd_ff      <= '0;
      end else begin
         if (pb_en) begin
            shift_ff <= shift_in;
            nbits_ff <= nbits_in;
            if (pb_done && wr_cnt_ff < BUF_CW'(MAX_OUT)) begin
               buf_ff[wr_cnt_ff[BUF_AW-1:0]] <= {shift_ff, pb_bit};
               wr_cnt_ff <= wr_cnt_ff + 1'b1;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  slo_ff    <= slo_m;
                  shi_ff    <= shi_m;
                  tot_ff    <= tot_m;
                  ovf_ff    <= 1'b0;
                  wr_cnt_ff <= '0;
                  rd_ff     <= '0;
                  if (req_action == ACT_FINISH) begin
                     state_ff <= S_FIN;
                  end else if (req_ok) begin
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= (div_q == '0) ? S_IDLE : S_MULH;
               end
            end
            S_MULH: begin
               prod_ff  <= mul_p[RANGE_W-1:0];
               state_ff <= S_MULL;
            end
            S_MULL: begin
               high_ff  <= low_ff + prod_ff - RANGE_W'(1);
               prod_ff  <= mul_p[RANGE_W-1:0];
               state_ff <= S_ADDL;
            end
            S_ADDL: begin
               low_ff   <= low_ff + prod_ff;
               state_ff <= S_SHIFT;
            end
            S_SHIFT: begin
               if (renorm) begin
                  // both halves reduce to a plain shift of the 31-bit bounds
                  low_ff     <= {low_ff[RANGE_W-2:0], 1'b0};
                  high_ff    <= {high_ff[RANGE_W-2:0], 1'b1};
                  cur_bit_ff <= low_ff[RANGE_W-1];
                  if (pend_ff != '0) begin
                     emit_ff  <= EW'(pend_ff);
                     pend_ff  <= '0;
                     state_ff <= S_PEND;
                  end
               end else begin
                  state_ff <= S_UFLOW;
               end
            end
            S_PEND: begin
               emit_ff <= emit_ff - 1'b1;
               if (emit_ff == EW'(1)) begin
                  state_ff <= (high_ff == TOP && low_ff == '0 && pend_ff == '0
                               && fin_ff) ? S_PAD : S_SHIFT;
               end
            end
            S_UFLOW: begin
               if (uflow) begin
                  if (pend_ff < PW'(PENDING_MAX)) begin
                     pend_ff <= pend_ff + 1'b1;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  low_ff  <= RANGE_W'((low_ff - Q1) << 1);
                  high_ff <= RANGE_W'(((high_ff - Q1) << 1) | RANGE_W'(1));
               end else begin
                  state_ff <= (wr_cnt_ff != '0) ? S_OUT : S_IDLE;
               end
            end
            S_FIN: begin
               if (low_ff < Q1) begin
                  cur_bit_ff <= 1'b0;
                  emit_ff    <= EW'(pend_ff) + EW'(1);
                  state_ff   <= S_PEND;
               end else begin
                  state_ff <= S_PAD;
               end
               // coder state returns to reset; termination already decided
               low_ff  <= '0;
               high_ff <= TOP;
               pend_ff <= '0;
            end
            S_PAD: begin
               if (nbits_ff == '0) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  if (rd_ff == wr_cnt_ff - 1'b1) begin
                     state_ff <= S_IDLE;
                  end else begin
                     rd_ff <= rd_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else if (req_take) begin
         fin_ff <= (req_action == ACT_FINISH);
      end
   end

   assign rsp_valid    = (state_ff == S_OUT);
   assign rsp_out_byte = buf_ff[rd_ff[BUF_AW-1:0]];
   assign rsp_last     = (rd_ff == wr_cnt_ff - 1'b1);
   assign rsp_overflow = ovf_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      wr_cnt_ff <= BUF_CW'(MAX_OUT))
      else $error("byte buffer count beyond capacity");
   a_out_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (wr_cnt_ff != '0 && rd_ff < wr_cnt_ff))
      else $error("output without buffered byte");
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PW'(PENDING_MAX))
      else $error("pending count above limit");
   a_fin_reset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAD) |-> (low_ff == '0 && high_ff == TOP && pend_ff == '0))
      else $error("coder state not restored during padding");
`endif
endmodule
`default_nettype wire
